// File: rtl/five_point_first_derivative_unit_defines.svh
// assertion macros shared by the five point first derivative unit
// no dependencies; included by files that carry concurrent assertions
`ifndef FIVE_POINT_FIRST_DERIVATIVE_UNIT_DEFINES_SVH
`define FIVE_POINT_FIRST_DERIVATIVE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define FPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/fpd_pkg.sv
// types and constants of the five point first derivative unit
// no dependencies; used by fpd_stencil, fpd_scale and the top level
package fpd_pkg;

   localparam int SMP_W  = 32;
   localparam int SUM_W  = 40;
   localparam int MAG_W  = 39;
   localparam int POS_W  = 12;
   localparam int IDX_W  = 3;
   localparam int MAX_POINTS = 4096;

   localparam logic [POS_W-1:0] COUNT_MAX = 12'd4095;
   localparam logic [POS_W-1:0] POS_CAP   =
      POS_W'((MAX_POINTS > 4096) ? 4095 : MAX_POINTS - 1);

   // register map
   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_INV_SPACING = 1'b0;
   localparam logic [SMP_W-1:0] INV_SPACING_RESET = 32'd65536;

   // division by three: ceil(2^34 / 3), exact below 2^33
   localparam logic [32:0] RECIP3       = 33'd5726623062;
   // largest pre-division value whose quotient by three stays within 2^31
   localparam logic [32:0] SAT12_LIMIT  = 33'd6442450946;
   localparam logic [32:0] SAT1_LIMIT   = 33'h080000000;

   typedef enum logic [1:0] {
      DIV_ONE,
      DIV_TWO,
      DIV_TWELVE
   } div_type;

   typedef enum logic [2:0] {
      KIND_DIFF,
      KIND_FWD0,
      KIND_FWD1,
      KIND_CENT,
      KIND_BACK
   } kind_type;

   typedef logic [4:0][SMP_W-1:0] win_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             end_of_run;
   } tag_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      div_type                 div;
      tag_type                 tag;
   } scl_req_type;

   typedef struct packed {
      logic [POS_W-1:0] k;
      logic             fin;
      logic [IDX_W-1:0] idx;
   } job_type;

endpackage

// File: rtl/fpd_stencil.sv
// job decode and stencil sum: picks the formula for one output position
// depends on fpd_pkg
module fpd_stencil (
   input  fpd_pkg::win_type     window,
   input  fpd_pkg::job_type     job,
   output fpd_pkg::scl_req_type req
);

   logic signed [fpd_pkg::SUM_W-1:0] ws [5];
   fpd_pkg::kind_type                kind;
   fpd_pkg::div_type                 div;
   logic [fpd_pkg::IDX_W-1:0]        ia;
   logic [fpd_pkg::IDX_W-1:0]        ib;
   logic [fpd_pkg::IDX_W-1:0]        base;
   logic [fpd_pkg::POS_W-1:0]        pos_raw;
   logic                             last;
   logic signed [fpd_pkg::SUM_W-1:0] sum;

   // sign extend the window taps
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         ws[i] = fpd_pkg::SUM_W'($signed(window[i]));
      end
   end

   // formula selection from sample count and job index
   always_comb begin
      kind    = fpd_pkg::KIND_DIFF;
      div     = fpd_pkg::DIV_ONE;
      ia      = 3'd4;
      ib      = 3'd4;
      pos_raw = '0;
      last    = 1'b0;
      base    = 3'd4 - {1'b0, job.k[1:0]};
      if (job.k[fpd_pkg::POS_W-1:2] == '0) begin
         // short run: two-point differences
         if (job.k[1:0] == 2'd0) begin
            last = 1'b1;
         end else if (job.idx == 3'd0) begin
            ia = base + 3'd1;
            ib = base;
         end else if (job.idx == {1'b0, job.k[1:0]}) begin
            ia      = 3'd4;
            ib      = 3'd3;
            pos_raw = fpd_pkg::POS_W'(job.idx);
            last    = 1'b1;
         end else begin
            ia      = base + job.idx + 3'd1;
            ib      = base + job.idx - 3'd1;
            div     = fpd_pkg::DIV_TWO;
            pos_raw = fpd_pkg::POS_W'(job.idx);
         end
      end else if (job.k == 12'd4) begin
         // fifth sample: both one-sided heads, then the center, plus the tail on the final beat
         div = fpd_pkg::DIV_TWELVE;
         case (job.idx)
            3'd0: begin
               kind    = fpd_pkg::KIND_FWD0;
               pos_raw = 12'd0;
            end
            3'd1: begin
               kind    = fpd_pkg::KIND_FWD1;
               pos_raw = 12'd1;
            end
            3'd2: begin
               kind    = fpd_pkg::KIND_CENT;
               pos_raw = 12'd2;
            end
            3'd3: begin
               kind    = fpd_pkg::KIND_BACK;
               pos_raw = 12'd3;
            end
            default: begin
               kind    = fpd_pkg::KIND_BACK;
               pos_raw = 12'd4;
               last    = 1'b1;
            end
         endcase
      end else begin
         // steady state: center, plus the tail on the final beat
         div = fpd_pkg::DIV_TWELVE;
         case (job.idx)
            3'd0: begin
               kind    = fpd_pkg::KIND_CENT;
               pos_raw = job.k - 12'd2;
            end
            3'd1: begin
               kind    = fpd_pkg::KIND_BACK;
               pos_raw = job.k - 12'd1;
            end
            default: begin
               kind    = fpd_pkg::KIND_BACK;
               pos_raw = job.k;
               last    = 1'b1;
            end
         endcase
      end
   end

   // weighted sums of the window
   always_comb begin
      case (kind)
         fpd_pkg::KIND_FWD0:
            sum = ws[1] * 40'sd48 + ws[3] * 40'sd16
                - ws[0] * 40'sd25 - ws[2] * 40'sd36 - ws[4] * 40'sd3;
         fpd_pkg::KIND_FWD1:
            sum = ws[2] * 40'sd18 + ws[4]
                - ws[0] * 40'sd3 - ws[1] * 40'sd10 - ws[3] * 40'sd6;
         fpd_pkg::KIND_CENT:
            sum = ws[0] + ws[3] * 40'sd8 - ws[1] * 40'sd8 - ws[4];
         fpd_pkg::KIND_BACK:
            sum = ws[0] * 40'sd3 + ws[2] * 40'sd36 + ws[4] * 40'sd25
                - ws[1] * 40'sd16 - ws[3] * 40'sd48;
         default:
            sum = ws[ia] - ws[ib];
      endcase
   end

   // clamp position and pack the request
   always_comb begin
      req.sum            = sum;
      req.div            = div;
      req.tag.position   = (pos_raw > fpd_pkg::POS_CAP) ? fpd_pkg::POS_CAP : pos_raw;
      req.tag.end_of_run = last;
   end

endmodule

// File: rtl/fpd_scale.sv
// five stage scaling pipeline: sum times reciprocal, rounded divide, saturate
// depends on fpd_pkg
module fpd_scale (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [fpd_pkg::SMP_W-1:0] inv_spacing,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  fpd_pkg::scl_req_type      in_req,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [fpd_pkg::SMP_W-1:0] out_slope,
   output fpd_pkg::tag_type          out_tag
);

   logic a_en, b_en, c_en, d_en, e_en;

   logic                      a_valid_ff;
   logic                      a_neg_ff;
   logic [fpd_pkg::MAG_W-1:0] a_mag_ff;
   logic [fpd_pkg::MAG_W-1:0] a_mag_in;
   logic [fpd_pkg::SUM_W-1:0] a_abs;
   fpd_pkg::div_type          a_div_ff;
   fpd_pkg::tag_type          a_tag_ff;

   logic                      b_valid_ff;
   logic                      b_neg_ff;
   logic [63:0]               b_lo_ff;
   logic [63:0]               b_lo_in;
   logic [38:0]               b_hi_ff;
   logic [38:0]               b_hi_in;
   fpd_pkg::div_type          b_div_ff;
   fpd_pkg::tag_type          b_tag_ff;

   logic                      c_valid_ff;
   logic                      c_neg_ff;
   logic [32:0]               c_x_ff;
   logic [32:0]               c_x_in;
   logic                      c_big_ff;
   logic                      c_big_in;
   logic [71:0]               c_prod;
   logic [71:0]               c_round;
   logic [71:0]               c_wide;
   fpd_pkg::div_type          c_div_ff;
   fpd_pkg::tag_type          c_tag_ff;

   logic                      d_valid_ff;
   logic                      d_neg_ff;
   logic                      d_big_ff;
   logic [32:0]               d_q_ff;
   logic [32:0]               d_q_in;
   logic [65:0]               d_prod;
   fpd_pkg::tag_type          d_tag_ff;

   logic                      e_valid_ff;
   logic [fpd_pkg::SMP_W-1:0] e_slope_ff;
   logic [fpd_pkg::SMP_W-1:0] e_slope_in;
   fpd_pkg::tag_type          e_tag_ff;

   // stage enables: a stage moves when empty or when its successor moves
   assign e_en     = !e_valid_ff || out_ready;
   assign d_en     = !d_valid_ff || e_en;
   assign c_en     = !c_valid_ff || d_en;
   assign b_en     = !b_valid_ff || c_en;
   assign a_en     = !a_valid_ff || b_en;
   assign in_ready = a_en;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (a_en) a_valid_ff <= in_valid;
         if (b_en) b_valid_ff <= a_valid_ff;
         if (c_en) c_valid_ff <= b_valid_ff;
         if (d_en) d_valid_ff <= c_valid_ff;
         if (e_en) e_valid_ff <= d_valid_ff;
      end
   end

   // stage a: sign and magnitude of the stencil sum
   always_comb begin
      a_abs    = in_req.sum[fpd_pkg::SUM_W-1] ? fpd_pkg::SUM_W'(-in_req.sum)
                                              : fpd_pkg::SUM_W'(in_req.sum);
      a_mag_in = a_abs[fpd_pkg::MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_neg_ff <= in_req.sum[fpd_pkg::SUM_W-1];
         a_mag_ff <= a_mag_in;
         a_div_ff <= in_req.div;
         a_tag_ff <= in_req.tag;
      end
   end

   // stage b: two partial products against the reciprocal
   assign b_lo_in = 64'(a_mag_ff[31:0]) * 64'(inv_spacing);
   assign b_hi_in = 39'(a_mag_ff[38:32]) * 39'(inv_spacing);

   always_ff @(posedge clock) begin
      if (b_en) begin
         b_neg_ff <= a_neg_ff;
         b_lo_ff  <= b_lo_in;
         b_hi_ff  <= b_hi_in;
         b_div_ff <= a_div_ff;
         b_tag_ff <= a_tag_ff;
      end
   end

   // stage c: join partials, add half the divisor, shift, flag overflow
   always_comb begin
      c_prod = 72'(b_lo_ff) + (72'(b_hi_ff) << 32);
      case (b_div_ff)
         fpd_pkg::DIV_TWO: begin
            c_round  = 72'(17'h10000);
            c_wide   = (c_prod + c_round) >> 17;
            c_big_in = c_wide > 72'(fpd_pkg::SAT1_LIMIT);
         end
         fpd_pkg::DIV_TWELVE: begin
            c_round  = 72'(19'h60000);
            c_wide   = (c_prod + c_round) >> 18;
            c_big_in = c_wide > 72'(fpd_pkg::SAT12_LIMIT);
         end
         default: begin
            c_round  = 72'(16'h8000);
            c_wide   = (c_prod + c_round) >> 16;
            c_big_in = c_wide > 72'(fpd_pkg::SAT1_LIMIT);
         end
      endcase
      c_x_in = c_wide[32:0];
   end

   always_ff @(posedge clock) begin
      if (c_en) begin
         c_neg_ff <= b_neg_ff;
         c_x_ff   <= c_x_in;
         c_big_ff <= c_big_in;
         c_div_ff <= b_div_ff;
         c_tag_ff <= b_tag_ff;
      end
   end

   // stage d: divide by three through the reciprocal for the stencils
   assign d_prod = 66'(c_x_ff) * 66'(fpd_pkg::RECIP3);
   assign d_q_in = (c_div_ff == fpd_pkg::DIV_TWELVE) ? {1'b0, d_prod[65:34]} : c_x_ff;

   always_ff @(posedge clock) begin
      if (d_en) begin
         d_neg_ff <= c_neg_ff;
         d_big_ff <= c_big_ff;
         d_q_ff   <= d_q_in;
         d_tag_ff <= c_tag_ff;
      end
   end

   // stage e: restore sign and saturate to q16.16
   always_comb begin
      if (d_neg_ff) begin
         if (d_big_ff || (d_q_ff > 33'h080000000)) begin
            e_slope_in = 32'h80000000;
         end else begin
            e_slope_in = 32'(~d_q_ff + 33'd1);
         end
      end else begin
         if (d_big_ff || (d_q_ff > 33'h07fffffff)) begin
            e_slope_in = 32'h7fffffff;
         end else begin
            e_slope_in = d_q_ff[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (e_en) begin
         e_slope_ff <= e_slope_in;
         e_tag_ff   <= d_tag_ff;
      end
   end

   assign out_valid = e_valid_ff;
   assign out_slope = e_slope_ff;
   assign out_tag   = e_tag_ff;

endmodule

// File: rtl/five_point_first_derivative_unit.sv
// top level of the five point first derivative unit: window, job sequencer, csr
// depends on fpd_pkg, fpd_stencil, fpd_scale and the assertion macro header
//
// Each accepted sample shifts into a five-tap window and yields 0 to 5
// derivative beats: samples 0..3 of a run yield none unless final, a
// non-final sample from the fifth on yields one (three for the fifth), and a
// final sample yields every position still open (up to five). The derivative
// beats of one sample go out of the job sequencer one per cycle into a five
// stage scaling pipeline, except while it is not ready, and the next sample
// is taken in the cycle its last job leaves, so a beat that makes more than
// one job holds the input until that last job leaves. A derivative passes
// the stage a to e registers of the pipeline after the job that makes it.
// The pipeline keeps moving while free slots remain, so sample beats are
// still taken while a result waits on rsp_ready. inv_spacing is written
// through the APB port at address 0; the user must write it only while the
// unit is idle, which the block itself does not enforce; pready is always high.
`include "five_point_first_derivative_unit_defines.svh"

module five_point_first_derivative_unit (
   input  logic                      clock,
   input  logic                      reset,
   // sample channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_sample,
   input  logic                      req_final_req,
   // derivative channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [31:0]        rsp_slope,
   output logic [11:0]               rsp_position,
   output logic                      rsp_end_of_run,
   // configuration port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic [fpd_pkg::SMP_W-1:0]     inv_spacing_ff;
   logic [fpd_pkg::REG_IDX_W-1:0] reg_idx;
   logic                          csr_write;

   fpd_pkg::win_type              window_ff;
   fpd_pkg::win_type              window_in;
   logic [fpd_pkg::POS_W-1:0]     count_ff;
   logic [fpd_pkg::POS_W-1:0]     count_in;

   logic                          busy_ff;
   fpd_pkg::job_type              job_ff;
   logic [fpd_pkg::IDX_W-1:0]     njobs_ff;
   logic [fpd_pkg::IDX_W-1:0]     njobs_in;

   logic                          accept;
   logic                          issue;
   logic                          last_issue;
   logic                          short_run;
   logic                          fifth;

   fpd_pkg::scl_req_type          scl_req;
   logic                          scl_ready;
   logic [fpd_pkg::SMP_W-1:0]     scl_slope;
   fpd_pkg::tag_type              scl_tag;

   // configuration register
   assign pready    = 1'b1;
   assign reg_idx   = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (reg_idx == fpd_pkg::REG_INV_SPACING) ? inv_spacing_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_spacing_ff <= fpd_pkg::INV_SPACING_RESET;
      end else if (csr_write && (reg_idx == fpd_pkg::REG_INV_SPACING)) begin
         inv_spacing_ff <= pwdata;
      end
   end

   // handshake: a new sample once the previous one has issued its last job
   assign issue      = busy_ff && scl_ready;
   assign last_issue = issue && (job_ff.idx == njobs_ff - 3'd1);
   assign req_ready  = !busy_ff || last_issue;
   assign accept     = req_valid && req_ready;

   // window shift, saturating count and number of jobs for this beat
   always_comb begin
      window_in = {req_sample, window_ff[4:1]};
      short_run = (count_ff[fpd_pkg::POS_W-1:2] == '0);
      fifth     = (count_ff == 12'd4);
      if (req_final_req) begin
         count_in = '0;
      end else if (count_ff < fpd_pkg::COUNT_MAX) begin
         count_in = count_ff + 12'd1;
      end else begin
         count_in = count_ff;
      end
      if (req_final_req) begin
         njobs_in = short_run ? ({1'b0, count_ff[1:0]} + 3'd1) : (fifth ? 3'd5 : 3'd3);
      end else begin
         njobs_in = short_run ? 3'd0 : (fifth ? 3'd3 : 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff  <= '0;
         busy_ff   <= 1'b0;
         job_ff    <= '0;
         njobs_ff  <= '0;
      end else if (accept) begin
         window_ff  <= window_in;
         count_ff   <= count_in;
         busy_ff    <= (njobs_in != 3'd0);
         job_ff.k   <= count_ff;
         job_ff.fin <= req_final_req;
         job_ff.idx <= '0;
         njobs_ff   <= njobs_in;
      end else if (issue) begin
         job_ff.idx <= job_ff.idx + 3'd1;
         if (last_issue) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // formula decode and stencil sum
   fpd_stencil u_stencil (
      .window (window_ff),
      .job    (job_ff),
      .req    (scl_req)
   );

   // scaling pipeline with the output register
   fpd_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .inv_spacing (inv_spacing_ff),
      .in_valid    (busy_ff),
      .in_ready    (scl_ready),
      .in_req      (scl_req),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_slope   (scl_slope),
      .out_tag     (scl_tag)
   );

   assign rsp_slope      = $signed(scl_slope);
   assign rsp_position   = scl_tag.position;
   assign rsp_end_of_run = scl_tag.end_of_run;

   // sequencer checks
   `FPD_ASSERT_IMP(a_idx_range, clock, reset, busy_ff, job_ff.idx < njobs_ff,
      "job index past job count")
   `FPD_ASSERT_IMP(a_end_on_last, clock, reset, issue,
      scl_req.tag.end_of_run == (last_issue && job_ff.fin),
      "end of run flag not on the last job of a final beat")
   `FPD_ASSERT_NEXT(a_final_restart, clock, reset, accept && req_final_req,
      (count_ff == '0) && busy_ff, "final beat did not restart the count")

endmodule

// File: tb/tb.sv
// self-checking testbench for five_point_first_derivative_unit
// depends on fpd_pkg and the unit; predicts every derivative beat on its own
module tb;

   localparam logic [2:0]  ADDR_INV_SPACING = 3'(4 * fpd_pkg::REG_INV_SPACING);
   localparam logic [2:0]  ADDR_UNMAPPED    = 3'd4;
   localparam int unsigned DIV_FIVE_POINT   = 12;
   localparam int unsigned DIV_END          = 1;
   localparam int unsigned DIV_CENTRAL      = 2;
   localparam int          DRAIN_CYCLES     = 16;
   localparam int          PHASE_ITEMS      = 24;

   typedef struct packed {
      logic [31:0] slope;
      logic [11:0] position;
      logic        end_of_run;
   } deriv_type;

   typedef struct packed {
      logic [31:0] smp;
      logic        fin;
      logic        typed;
      logic [31:0] slope;
      logic [11:0] position;
      logic        end_of_run;
   } row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_sample;
   logic               req_final_req;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_slope;
   logic [11:0]        rsp_position;
   logic               rsp_end_of_run;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   // predictor state
   logic signed [31:0] taps [5];
   logic [11:0]        run_count;
   logic [31:0]        inv_spacing_q;
   deriv_type          pending_derivs [$];

   int mismatches  = 0;
   int beats_seen  = 0;
   int burst_left  = 0;

   five_point_first_derivative_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_final_req  (req_final_req),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_slope      (rsp_slope),
      .rsp_position   (rsp_position),
      .rsp_end_of_run (rsp_end_of_run),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // weighted sum over the window, oldest tap first
   function automatic logic signed [63:0] weigh(input int c0, input int c1, input int c2,
                                                input int c3, input int c4);
      return longint'(c0) * taps[0] + longint'(c1) * taps[1] + longint'(c2) * taps[2]
           + longint'(c3) * taps[3] + longint'(c4) * taps[4];
   endfunction

   function automatic logic signed [63:0] tap_diff(input int a, input int b);
      return longint'(taps[a]) - longint'(taps[b]);
   endfunction

   // sum * inv_spacing / (div * 2^16), rounded half away from zero, saturated
   function automatic logic [31:0] scale_sum(input logic signed [63:0] acc,
                                             input int unsigned div);
      logic         neg;
      logic [63:0]  mag;
      logic [127:0] prod;
      logic [127:0] den;
      logic [127:0] quo;
      neg  = acc < 0;
      mag  = neg ? -acc : acc;
      den  = 128'(div) << 16;
      prod = {64'd0, mag} * {96'd0, inv_spacing_q};
      quo  = (prod + (den >> 1)) / den;
      if (neg)
         return (quo > 128'h8000_0000) ? 32'h8000_0000 : 32'h0 - quo[31:0];
      return (quo > 128'h7fff_ffff) ? 32'h7fff_ffff : quo[31:0];
   endfunction

   function automatic void expect_beat(input logic keep, input logic [31:0] slope,
                                       input int pos, input logic eor);
      deriv_type d;
      d.slope      = slope;
      d.position   = (pos > int'(fpd_pkg::POS_CAP)) ? fpd_pkg::POS_CAP : 12'(pos);
      d.end_of_run = eor;
      if (keep)
         pending_derivs = {pending_derivs, d};
   endfunction

   // advance the predictor by one sample and queue the derivatives it yields
   function automatic void predict(input logic [31:0] smp, input logic fin, input logic keep);
      int          k;
      int          n;
      int          base;
      logic [31:0] back;
      k = int'(run_count);
      for (int i = 0; i < 4; i++)
         taps[i] = taps[i + 1];
      taps[4] = smp;
      if (k < 4) begin
         // short run: plain two-point differences, a lone sample gives zero
         if (fin) begin
            n    = k + 1;
            base = 4 - k;
            if (n == 1) begin
               expect_beat(keep, 32'h0, 0, 1'b1);
            end else begin
               expect_beat(keep, scale_sum(tap_diff(base + 1, base), DIV_END), 0, 1'b0);
               for (int j = 1; j + 1 < n; j++)
                  expect_beat(keep, scale_sum(tap_diff(base + j + 1, base + j - 1),
                                              DIV_CENTRAL), j, 1'b0);
               expect_beat(keep, scale_sum(tap_diff(base + n - 1, base + n - 2), DIV_END),
                           n - 1, 1'b1);
            end
         end
      end else begin
         // one-sided formulas for the first two positions
         if (k == 4) begin
            expect_beat(keep, scale_sum(weigh(-25, 48, -36, 16, -3), DIV_FIVE_POINT),
                        0, 1'b0);
            expect_beat(keep, scale_sum(weigh(-3, -10, 18, -6, 1), DIV_FIVE_POINT),
                        1, 1'b0);
         end
         expect_beat(keep, scale_sum(weigh(1, -8, 0, 8, -1), DIV_FIVE_POINT), k - 2, 1'b0);
         // backward formula, repeated for the last position
         if (fin) begin
            back = scale_sum(weigh(3, -16, 36, -48, 25), DIV_FIVE_POINT);
            expect_beat(keep, back, k - 1, 1'b0);
            expect_beat(keep, back, k, 1'b1);
         end
      end
      if (fin)
         run_count = '0;
      else if (run_count < fpd_pkg::COUNT_MAX)
         run_count = run_count + 12'd1;
   endfunction

   // send one sample beat, with bursts and random gaps on the sender side
   task automatic offer(input logic [31:0] smp, input logic fin, input logic typed,
                        input deriv_type typed_beat);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid     <= 1'b1;
      req_sample    <= smp;
      req_final_req <= fin;
      do @(posedge clock); while (!req_ready);
      predict(smp, fin, !typed);
      if (typed)
         pending_derivs = {pending_derivs, typed_beat};
      burst_left--;
   endtask

   // wait for every expected beat, then let the unit drain
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_derivs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_INV_SPACING)
         inv_spacing_q = data;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [2:0] addr);
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (got !== inv_spacing_q) begin
         $error("inv_spacing: expected %0h, got %0h", inv_spacing_q, got);
         mismatches++;
      end
   endtask

   function automatic logic [31:0] pick_sample(input int style, input int i,
                                               input logic [31:0] base,
                                               input logic [31:0] step);
      case (style)
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'hffff_ffff;
            endcase
         end
         2: return base + step * i;
         default: return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
      endcase
   endfunction

   // derivative beat checker
   always @(posedge clock) begin : check_beats
      deriv_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_seen++;
         if (pending_derivs.size() == 0) begin
            $error("derivative beat with nothing expected: slope %0h position %0d",
                   rsp_slope, rsp_position);
            mismatches++;
         end else begin
            want = pending_derivs.pop_front();
            if (rsp_slope !== want.slope) begin
               $error("slope: expected %0h, got %0h", want.slope, rsp_slope);
               mismatches++;
            end
            if (rsp_position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_position);
               mismatches++;
            end
            if (rsp_end_of_run !== want.end_of_run) begin
               $error("end_of_run: expected %0b, got %0b", want.end_of_run, rsp_end_of_run);
               mismatches++;
            end
         end
      end
   end

   // receiver: rotating stall patterns plus long hold-offs to back up the unit
   initial begin : drain_side
      int cyc;
      int hold;
      int next_squeeze;
      cyc          = 0;
      hold         = 0;
      next_squeeze = 30;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (beats_seen >= next_squeeze) begin
            hold         = (next_squeeze == 30) ? 120 : 400;
            next_squeeze = (next_squeeze == 30) ? 2000 : 32'h7fff_ffff;
            rsp_ready <= 1'b0;
         end else begin
            case ((cyc / 50) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (cyc % 3) == 0;
               default: rsp_ready <= $urandom_range(0, 3) != 0;
            endcase
         end
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      row_type     dir_rows [23];
      logic [31:0] inv_plan [5];
      deriv_type   typed_beat;
      int          seq_len;
      int          style;
      int          items;
      logic [31:0] base;
      logic [31:0] step;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_sample    <= '0;
      req_final_req <= 1'b0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      for (int i = 0; i < 5; i++)
         taps[i] = '0;
      run_count     = '0;
      inv_spacing_q = fpd_pkg::INV_SPACING_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(ADDR_INV_SPACING);

      // directed: lone samples, short runs, a five-sample run, a quadratic ramp
      dir_rows = '{
         '{32'h0000_0000, 1'b1, 1'b1, 32'h0, 12'd0, 1'b1},
         '{32'h7fff_ffff, 1'b1, 1'b1, 32'h0, 12'd0, 1'b1},
         '{32'h8000_0000, 1'b1, 1'b1, 32'h0, 12'd0, 1'b1},
         '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h7fff_ffff, 1'b1, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h0001_0000, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h0003_0000, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h0006_0000, 1'b1, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h7fff_ffff, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'hffff_ffff, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h0000_0001, 1'b1, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h7fff_ffff, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h7fff_ffff, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h7fff_ffff, 1'b1, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h0001_0000, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h0004_0000, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h0009_0000, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h0010_0000, 1'b0, 1'b0, 32'h0, 12'd0, 1'b0},
         '{32'h0019_0000, 1'b1, 1'b0, 32'h0, 12'd0, 1'b0}
      };
      foreach (dir_rows[r]) begin
         typed_beat = '{dir_rows[r].slope, dir_rows[r].position, dir_rows[r].end_of_run};
         offer(dir_rows[r].smp, dir_rows[r].fin, dir_rows[r].typed, typed_beat);
      end
      settle();

      // random runs under several spacings, the extremes and zero among them
      inv_plan = '{32'h1, 32'hffff_ffff, 32'h0, $urandom, 32'h0001_0000};
      for (int phase = 0; phase < 5; phase++) begin
         csr_write(ADDR_INV_SPACING, inv_plan[phase]);
         csr_check(ADDR_INV_SPACING);
         // writes to an unmapped address must leave the register alone
         if (phase == 1) begin
            csr_write(ADDR_UNMAPPED, $urandom);
            csr_check(ADDR_INV_SPACING);
         end
         items = 0;
         while (items < PHASE_ITEMS) begin
            seq_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                 : $urandom_range(9, 30);
            style   = $urandom_range(0, 3);
            base    = $urandom;
            step    = 32'($urandom_range(0, 32'h3_ffff)) - 32'h1_ffff;
            for (int i = 0; i < seq_len; i++)
               offer(pick_sample(style, i, base, step), i == seq_len - 1, 1'b0, '0);
            items += seq_len;
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/fpd_pkg.sv
rtl/fpd_stencil.sv
rtl/fpd_scale.sv
rtl/five_point_first_derivative_unit.sv
tb/tb.sv
